FILE: design/bank_of_fixed_capacity_lists_defines.svh
// ----------------------------------------------------------------------------
// Bank of fixed-capacity lists: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BANK_OF_FIXED_CAPACITY_LISTS_DEFINES_SVH
`define BANK_OF_FIXED_CAPACITY_LISTS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BOFCL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BOFCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bofcl_pkg.sv
// ----------------------------------------------------------------------------
// Bank of fixed-capacity lists: package
// Field widths, operation and status codes, and the list table update type.
// ----------------------------------------------------------------------------
package bofcl_pkg;

    localparam int OP_W     = 3;
    localparam int LIST_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int CAPREQ_W = 16;
    localparam int STATUS_W = 4;

    localparam logic [OP_W-1:0] OP_CREATE   = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND   = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_LAST = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_VAL  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 4'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 4'd3;
    localparam logic [STATUS_W-1:0] ST_NO_MEM    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 4'd5;
    localparam logic [STATUS_W-1:0] ST_ABSENT    = 4'd6;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd7;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 4'd8;

    localparam logic [1:0] UPD_NONE   = 2'd0;
    localparam logic [1:0] UPD_CREATE = 2'd1;
    localparam logic [1:0] UPD_INC    = 2'd2;
    localparam logic [1:0] UPD_DEC    = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [LIST_W-1:0] list;
    } tbl_upd_t;

endpackage

FILE: design/bofcl_if.sv
// ----------------------------------------------------------------------------
// Bank of fixed-capacity lists: channel interfaces
// Request and response channels with a valid/ready handshake per word.
// ----------------------------------------------------------------------------
interface bofcl_req_if;
    import bofcl_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic [LIST_W-1:0]          list_number;
    logic signed [VALUE_W-1:0]  item_value;
    logic signed [CAPREQ_W-1:0] capacity_request;

    modport source (output valid, output operation, output list_number,
                    output item_value, output capacity_request, input ready);
    modport sink   (input valid, input operation, input list_number,
                    input item_value, input capacity_request, output ready);
endinterface

interface bofcl_rsp_if;
    import bofcl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] element;
    logic                      element_valid;
    logic                      last;

    modport source (output valid, output status, output element,
                    output element_valid, output last, input ready);
    modport sink   (input valid, input status, input element,
                    input element_valid, input last, output ready);
endinterface

FILE: design/bofcl_elem_ram.sv
// ----------------------------------------------------------------------------
// Bank of fixed-capacity lists: element store
// One write port and one read port; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module bofcl_elem_ram #(
    parameter int DEPTH = 160,
    parameter int AW    = 8
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [AW-1:0]                    waddr,
    input  logic [bofcl_pkg::VALUE_W-1:0]    wdata,
    input  logic                             re,
    input  logic [AW-1:0]                    raddr,
    output logic [bofcl_pkg::VALUE_W-1:0]    rdata
);
    import bofcl_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/bofcl_list_table.sv
// ----------------------------------------------------------------------------
// Bank of fixed-capacity lists: list table
// Existence flag, capacity and fill count of every list, with one lookup
// port and one update port.
// ----------------------------------------------------------------------------
module bofcl_list_table #(
    parameter int NUM_LISTS    = 10,
    parameter int MAX_CAPACITY = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [bofcl_pkg::LIST_W-1:0]            rd_list,
    output logic                                    cur_exists,
    output logic [$clog2(MAX_CAPACITY+1)-1:0]       cur_cap,
    output logic [$clog2(MAX_CAPACITY+1)-1:0]       cur_cnt,
    input  bofcl_pkg::tbl_upd_t                     upd,
    input  logic [$clog2(MAX_CAPACITY+1)-1:0]       upd_cap
);
    import bofcl_pkg::*;

    localparam int CW    = $clog2(MAX_CAPACITY + 1);
    localparam int IDX_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

    logic          exists_reg [NUM_LISTS];
    logic [CW-1:0] cap_reg    [NUM_LISTS];
    logic [CW-1:0] cnt_reg    [NUM_LISTS];

    logic             rd_in_range;
    logic             wr_in_range;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;

    assign rd_in_range = rd_list < LIST_W'(NUM_LISTS);
    assign wr_in_range = upd.list < LIST_W'(NUM_LISTS);
    assign rd_idx      = rd_list[IDX_W-1:0];
    assign wr_idx      = upd.list[IDX_W-1:0];

    // A list number outside the bank reads as a list that does not exist.
    assign cur_exists = rd_in_range ? exists_reg[rd_idx] : 1'b0;
    assign cur_cap    = rd_in_range ? cap_reg[rd_idx] : '0;
    assign cur_cnt    = rd_in_range ? cnt_reg[rd_idx] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                exists_reg[i] <= 1'b0;
                cap_reg[i]    <= '0;
                cnt_reg[i]    <= '0;
            end
        end
        else if (upd.valid && wr_in_range)
        begin
            case (upd.kind)
                UPD_CREATE:
                begin
                    exists_reg[wr_idx] <= 1'b1;
                    cap_reg[wr_idx]    <= upd_cap;
                    cnt_reg[wr_idx]    <= '0;
                end
                UPD_INC: cnt_reg[wr_idx] <= cnt_reg[wr_idx] + CW'(1);
                UPD_DEC: cnt_reg[wr_idx] <= cnt_reg[wr_idx] - CW'(1);
                default: ;
            endcase
        end
    end

endmodule

FILE: design/bofcl_ctrl.sv
// ----------------------------------------------------------------------------
// Bank of fixed-capacity lists: sequencer
// Takes one request word at a time, checks it against the list table,
// walks the element store for searches, shifts and read-outs, and drives
// the registered response word.
// ----------------------------------------------------------------------------
module bofcl_ctrl #(
    parameter int NUM_LISTS    = 10,
    parameter int MAX_CAPACITY = 16
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    bofcl_req_if.sink                                             req,
    bofcl_rsp_if.source                                           rsp,
    output logic [bofcl_pkg::LIST_W-1:0]                          lookup_list,
    input  logic                                                  cur_exists,
    input  logic [$clog2(MAX_CAPACITY+1)-1:0]                     cur_cap,
    input  logic [$clog2(MAX_CAPACITY+1)-1:0]                     cur_cnt,
    output bofcl_pkg::tbl_upd_t                                   upd,
    output logic [$clog2(MAX_CAPACITY+1)-1:0]                     upd_cap,
    output logic                                                  ram_we,
    output logic [((NUM_LISTS*MAX_CAPACITY > 1) ?
                   $clog2(NUM_LISTS*MAX_CAPACITY) : 1)-1:0]       ram_waddr,
    output logic [bofcl_pkg::VALUE_W-1:0]                         ram_wdata,
    output logic                                                  ram_re,
    output logic [((NUM_LISTS*MAX_CAPACITY > 1) ?
                   $clog2(NUM_LISTS*MAX_CAPACITY) : 1)-1:0]       ram_raddr,
    input  logic [bofcl_pkg::VALUE_W-1:0]                         ram_rdata
);
    import bofcl_pkg::*;

    localparam int CW = $clog2(MAX_CAPACITY + 1);
    localparam int AW = (NUM_LISTS * MAX_CAPACITY > 1) ?
                        $clog2(NUM_LISTS * MAX_CAPACITY) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_EMIT   = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_READW  = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [OP_W-1:0]      op_reg;
    logic [LIST_W-1:0]    num_reg;
    logic [VALUE_W-1:0]   val_reg;
    logic [CAPREQ_W-1:0]  capreq_reg;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        at_reg, at_next;
    logic                 found_reg, found_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [CW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [1:0]           upd_kind_reg, upd_kind_next;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [VALUE_W-1:0]   out_elem_reg;
    logic                 out_ev_reg;
    logic                 out_last_reg;

    logic                 accept;
    logic                 out_free;
    logic                 push;
    logic [STATUS_W-1:0]  push_status;
    logic [VALUE_W-1:0]   push_elem;
    logic                 push_ev;
    logic                 push_last;
    logic                 upd_valid;
    logic [LIST_W-1:0]    li;
    logic                 in_range;
    logic [AW-1:0]        base;
    logic                 match;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign li       = num_reg - LIST_W'(1);
    assign in_range = (num_reg != '0) && (num_reg <= LIST_W'(NUM_LISTS));
    assign base     = AW'(li) * AW'(MAX_CAPACITY);
    assign match    = ram_rdata == val_reg;

    assign lookup_list = li;
    assign upd_cap     = capreq_reg[CW-1:0];
    assign upd.valid   = upd_valid;
    assign upd.kind    = upd_kind_reg;
    assign upd.list    = li;
    assign ram_wdata   = (state_reg == S_SHIFT) ? ram_rdata : val_reg;
    assign ram_raddr   = base + AW'(idx_reg);

    assign req.ready         = state_reg == S_IDLE;
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.element       = out_elem_reg;
    assign rsp.element_valid = out_ev_reg;
    assign rsp.last          = out_last_reg;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        at_next       = at_reg;
        found_next    = found_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        status_next   = status_reg;
        upd_kind_next = upd_kind_reg;
        push          = 1'b0;
        push_status   = ST_OK;
        push_elem     = '0;
        push_ev       = 1'b0;
        push_last     = 1'b1;
        ram_we        = 1'b0;
        ram_waddr     = base + AW'(cur_cnt);
        ram_re        = 1'b0;
        upd_valid     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                state_next    = S_EMIT;
                upd_kind_next = UPD_NONE;
                status_next   = ST_OK;
                if (op_reg > OP_READ)
                begin
                    state_next = S_IDLE;
                end
                else if (!in_range)
                begin
                    status_next = ST_BAD_POS;
                end
                else if (op_reg == OP_CREATE)
                begin
                    if (cur_exists)
                    begin
                        status_next = ST_EXISTS;
                    end
                    else if (capreq_reg[CAPREQ_W-1] || capreq_reg == '0)
                    begin
                        status_next = ST_BAD_SIZE;
                    end
                    else if (capreq_reg > CAPREQ_W'(MAX_CAPACITY))
                    begin
                        status_next = ST_NO_MEM;
                    end
                    else
                    begin
                        upd_kind_next = UPD_CREATE;
                    end
                end
                else if (!cur_exists)
                begin
                    status_next = ST_ABSENT;
                end
                else
                begin
                    case (op_reg)
                        OP_APPEND:
                        begin
                            if (cur_cnt >= cur_cap)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we        = 1'b1;
                                upd_kind_next = UPD_INC;
                            end
                        end
                        OP_REM_LAST:
                        begin
                            if (cur_cnt == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                upd_kind_next = UPD_DEC;
                            end
                        end
                        OP_REM_VAL:
                        begin
                            if (cur_cnt == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                                idx_next   = '0;
                                found_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            // Read-out of an empty list gives one plain OK word.
                            if (cur_cnt != '0)
                            begin
                                state_next = S_READ;
                                idx_next   = '0;
                            end
                        end
                    endcase
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    push        = 1'b1;
                    push_status = status_reg;
                    upd_valid   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_SEARCH:
            begin
                if (idx_reg < cur_cnt)
                begin
                    ram_re       = 1'b1;
                    idx_next     = idx_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg;
                end
                if (cmp_vld_reg)
                begin
                    if (match)
                    begin
                        found_next = 1'b1;
                        at_next    = cmp_idx_reg;
                    end
                    // The last compare decides; the latest match wins.
                    if (cmp_idx_reg + CW'(1) == cur_cnt)
                    begin
                        if (match || found_reg)
                        begin
                            state_next   = S_SHIFT;
                            idx_next     = (match ? cmp_idx_reg : at_reg) + CW'(1);
                            cmp_vld_next = 1'b0;
                        end
                        else
                        begin
                            status_next   = ST_NOT_FOUND;
                            upd_kind_next = UPD_NONE;
                            state_next    = S_EMIT;
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                // Read entry j, and write it to j-1 in the following cycle.
                if (cmp_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = base + AW'(cmp_idx_reg - CW'(1));
                end
                if (idx_reg < cur_cnt)
                begin
                    ram_re       = 1'b1;
                    idx_next     = idx_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg;
                end
                else if (!cmp_vld_reg)
                begin
                    status_next   = ST_OK;
                    upd_kind_next = UPD_DEC;
                    state_next    = S_EMIT;
                end
            end

            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_READW;
            end

            S_READW:
            begin
                if (out_free)
                begin
                    push      = 1'b1;
                    push_elem = ram_rdata;
                    push_ev   = 1'b1;
                    push_last = (idx_reg + CW'(1)) == cur_cnt;
                    if (push_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_READ;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            num_reg        <= '0;
            val_reg        <= '0;
            capreq_reg     <= '0;
            idx_reg        <= '0;
            at_reg         <= '0;
            found_reg      <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            status_reg     <= ST_OK;
            upd_kind_reg   <= UPD_NONE;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_elem_reg   <= '0;
            out_ev_reg     <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            at_reg       <= at_next;
            found_reg    <= found_next;
            cmp_vld_reg  <= cmp_vld_next;
            cmp_idx_reg  <= cmp_idx_next;
            status_reg   <= status_next;
            upd_kind_reg <= upd_kind_next;
            if (accept)
            begin
                op_reg     <= req.operation;
                num_reg    <= req.list_number;
                val_reg    <= req.item_value;
                capreq_reg <= req.capacity_request;
            end
            if (push)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= push_status;
                out_elem_reg   <= push_elem;
                out_ev_reg     <= push_ev;
                out_last_reg   <= push_last;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: design/bank_of_fixed_capacity_lists.sv
// Create, append and remove-last pass through the decide and emit states; emit waits
// until the response register is free. Remove-value searches the list, shifts the
// entries after the match down by one, then emits its word. Read-out reads an entry
// and gives its word before it reads the next. One request is taken at a time.
// Reset: rst_n clears the list table and control at once; the element store
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Bank of fixed-capacity lists
// Keeps NUM_LISTS numbered lists of up to MAX_CAPACITY signed words each and
// serves create, append, remove-last, remove-value and read-out requests.
// ----------------------------------------------------------------------------
`include "bank_of_fixed_capacity_lists_defines.svh"

module bank_of_fixed_capacity_lists #(
    parameter int NUM_LISTS    = 10,
    parameter int MAX_CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    bofcl_req_if.sink   req,
    bofcl_rsp_if.source rsp
);
    import bofcl_pkg::*;

    // Widths of a count or capacity, and of an element store address.
    localparam int CW    = $clog2(MAX_CAPACITY + 1);
    localparam int DEPTH = NUM_LISTS * MAX_CAPACITY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // The list table holds the small per-list descriptors in flip-flops; the
    // sequencer looks up the list of the current request and commits one
    // update when it sends the request's final word.
    logic [LIST_W-1:0] lookup_list;
    logic              cur_exists;
    logic [CW-1:0]     cur_cap;
    logic [CW-1:0]     cur_cnt;
    tbl_upd_t          upd;
    logic [CW-1:0]     upd_cap;

    // Element store: list n occupies MAX_CAPACITY consecutive entries.
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    // An append commits its count update in this cycle.
    logic               upd_inc;

    bofcl_list_table #(
        .NUM_LISTS    (NUM_LISTS),
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_list    (lookup_list),
        .cur_exists (cur_exists),
        .cur_cap    (cur_cap),
        .cur_cnt    (cur_cnt),
        .upd        (upd),
        .upd_cap    (upd_cap)
    );

    bofcl_elem_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The sequencer reads the store, compares or forwards the data, and
    // writes back. A shift writes entry j-1 with the entry read in the previous
    // cycle while reads run ahead, so no access overlaps an unfinished one.
    bofcl_ctrl #(
        .NUM_LISTS    (NUM_LISTS),
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .lookup_list (lookup_list),
        .cur_exists  (cur_exists),
        .cur_cap     (cur_cap),
        .cur_cnt     (cur_cnt),
        .upd         (upd),
        .upd_cap     (upd_cap),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    assign upd_inc = upd.valid && (upd.kind == UPD_INC);

    // A list never grows past its capacity.
    `BOFCL_ASSERT_SAME(a_inc_below_cap, upd_inc, cur_cnt < cur_cap, "append past capacity")

    // A table update goes out together with the request's final word.
    `BOFCL_ASSERT_NEXT(a_upd_with_last, upd.valid, rsp.valid && rsp.last, "no final word")

    // One request at a time: after acceptance the request side is closed.
    `BOFCL_ASSERT_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready, "accepted while busy")

endmodule
